/* rtl/core/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the stack permutation checker
// Store sizing, pointer widths, sequencer states and the result beat struct.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    // Store capacity in letters, for both the stack and the target queue
    parameter int MAX_LETTERS = 1024;

    parameter int LETTER_W = 8;
    // Address into a store, at least one bit
    parameter int ADDR_W   = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    // Counter that can hold the capacity itself
    parameter int CNT_W    = $clog2(MAX_LETTERS + 1);

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,    // take a pair, push and enqueue
        ST_READ,    // read stack top and queue head
        ST_CMP,     // compare, pop on match
        ST_WRAP     // hand over the word result
    } t_spc_state;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic reachable;
        logic overflow;
    } t_spc_result;

endpackage

`default_nettype wire

/* rtl/core/spc_in_if.sv */
// ----------------------------------------------------------------------------
// spc_in_if: letter pair channel
// One beat carries a source letter, a target letter and the last-pair mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_in_if;
    logic                         valid;
    logic                         ready;
    logic [spc_pkg::LETTER_W-1:0] source_letter;
    logic [spc_pkg::LETTER_W-1:0] target_letter;
    logic                         final_pair;

    modport source (output valid, output source_letter, output target_letter,
                    output final_pair, input ready);
    modport sink   (input valid, input source_letter, input target_letter,
                    input final_pair, output ready);
endinterface

`default_nettype wire

/* rtl/core/spc_out_if.sv */
// ----------------------------------------------------------------------------
// spc_out_if: word result channel
// One beat per word: reachable and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_out_if;
    logic valid;
    logic ready;
    logic reachable;
    logic overflow;

    modport source (output valid, output reachable, output overflow, input ready);
    modport sink   (input valid, input reachable, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/spc_ram.sv */
// ----------------------------------------------------------------------------
// spc_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/spc_ctrl.sv */
// ----------------------------------------------------------------------------
// spc_ctrl: stack/queue sequencer
// Pushes each source letter, enqueues each target letter, then pops while
// the stack top matches the queue head, alternating a RAM read and a compare.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    spc_in_if.sink            i_in,
    input  wire logic         i_slot_free,
    output spc_pkg::t_spc_result o_result
);
    import spc_pkg::*;

    t_spc_state r_state, n_state;
    t_cnt       r_depth, n_depth;
    t_cnt       r_head,  n_head;
    t_cnt       r_tail,  n_tail;
    logic       r_ovf,   n_ovf;
    logic       r_final, n_final;

    logic    push_we;
    logic    rd_en;
    t_letter stk_rdata;
    t_letter q_rdata;
    t_cnt    top_idx;

    assign top_idx = r_depth - t_cnt'(1);

    // letter stack: written at depth, read at depth-1
    spc_ram #(.DEPTH(MAX_LETTERS), .AW(ADDR_W), .DW(LETTER_W)) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (i_in.source_letter),
        .i_re    (rd_en),
        .i_raddr (top_idx[ADDR_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // target queue: written at tail, read at head
    spc_ram #(.DEPTH(MAX_LETTERS), .AW(ADDR_W), .DW(LETTER_W)) u_queue (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_tail[ADDR_W-1:0]),
        .i_wdata (i_in.target_letter),
        .i_re    (rd_en),
        .i_raddr (r_head[ADDR_W-1:0]),
        .o_rdata (q_rdata)
    );

    // state and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_depth <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ovf   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ovf   <= n_ovf;
            r_final <= n_final;
        end
    end

    // next state and controls
    always_comb begin
        n_state            = r_state;
        n_depth            = r_depth;
        n_head             = r_head;
        n_tail             = r_tail;
        n_ovf              = r_ovf;
        n_final            = r_final;
        push_we            = 1'b0;
        rd_en              = 1'b0;
        i_in.ready         = 1'b0;
        o_result.load      = 1'b0;
        o_result.reachable = (r_depth == '0) && !r_ovf;
        o_result.overflow  = r_ovf;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_final = i_in.final_pair;
                    if (r_tail == t_cnt'(MAX_LETTERS)) begin
                        // store full: drop the pair
                        n_ovf   = 1'b1;
                        n_state = i_in.final_pair ? ST_WRAP : ST_IDLE;
                    end else begin
                        push_we = 1'b1;
                        n_depth = r_depth + t_cnt'(1);
                        n_tail  = r_tail + t_cnt'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (r_depth != '0 && r_head != r_tail) begin
                    rd_en   = 1'b1;
                    n_state = ST_CMP;
                end else begin
                    n_state = r_final ? ST_WRAP : ST_IDLE;
                end
            end
            ST_CMP: begin
                if (stk_rdata == q_rdata) begin
                    // pop
                    n_depth = r_depth - t_cnt'(1);
                    n_head  = r_head + t_cnt'(1);
                    n_state = ST_READ;
                end else begin
                    n_state = r_final ? ST_WRAP : ST_IDLE;
                end
            end
            ST_WRAP: begin
                if (i_slot_free) begin
                    o_result.load = 1'b1;
                    n_depth       = '0;
                    n_head        = '0;
                    n_tail        = '0;
                    n_ovf         = 1'b0;
                    n_final       = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // every pop moves one letter from stack to matched queue head
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth + r_head) == r_tail)
        else $error("spc_ctrl: depth + head differs from tail");

    a_tail_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= t_cnt'(MAX_LETTERS))
        else $error("spc_ctrl: tail beyond capacity");

    a_load_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.load |-> r_final || r_ovf)
        else $error("spc_ctrl: result without final pair");

    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.load |=> (r_tail == '0) && !r_ovf && (r_state == ST_IDLE))
        else $error("spc_ctrl: word state not cleared after result");

    a_pop_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && stk_rdata == q_rdata) |=> r_state == ST_READ)
        else $error("spc_ctrl: match did not pop");

endmodule

`default_nettype wire

/* rtl/core/stack_permutation_checker_top.sv */
// ----------------------------------------------------------------------------
// stack_permutation_checker_top: stack permutation checker
// Decides per word whether the target word is a stack permutation of the
// source word, with an output register toward the result channel.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                     | beats
//  ---------+-----+---------------------------------------------+-------------
//  i_in     | in  | source_letter[8], target_letter[8], final_pair | one per pair
//  o_out    | out | reachable, overflow                         | one per word
//
//  A pair is pushed and enqueued, then each pop it triggers takes one RAM
//  read and one compare in the shared sequencer; a pair dropped at a full
//  store only sets the overflow flag. The last pair of a word then enters
//  the hand-over state. Pops never exceed pushes.
//  Reset clears the pointers and flags; the letter RAMs need no clearing.
//  A stalled result is held in the output register while the next word's
//  pairs are taken; only the next word's last pair waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_permutation_checker_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spc_in_if.sink    i_in,
    spc_out_if.source o_out
);
    import spc_pkg::*;

    t_spc_result result;
    logic        slot_free;
    logic        r_valid;
    logic        r_reachable;
    logic        r_overflow;

    assign slot_free = !r_valid || o_out.ready;

    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (slot_free),
        .o_result    (result)
    );

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (result.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (result.load) begin
            r_reachable <= result.reachable;
            r_overflow  <= result.overflow;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.reachable = r_reachable;
    assign o_out.overflow  = r_overflow;

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.load |-> (!r_valid || o_out.ready))
        else $error("top: result overwritten while stalled");

    a_overflow_unreachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_overflow |-> !r_reachable)
        else $error("top: overflowed word reported reachable");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.load |=> r_valid)
        else $error("top: loaded result not presented");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stack permutation checker regression
// Sends words as streams of letter pairs and compares every word verdict
// against a behavioral stack/queue predictor. A short table of hand-picked
// pairs runs first. Random words follow: mostly stack-reachable targets, some
// near misses and scrambles. One word runs past the store capacity. Both
// channels idle at random, and one phase holds the result channel off long
// enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int  RANDOM_PAIRS = 1530;
    localparam int  LONG_HOLD    = 500;
    localparam int  DRAIN_CYCLES = 64;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  N_DIRECTED   = 20;

    // One row of the directed table; typed rows carry their own verdict
    typedef struct packed {
        t_letter src;
        t_letter tgt;
        logic    fin;
        logic    typed;
        logic    exp_reach;
        logic    exp_ovf;
    } t_pair_row;

    typedef struct packed {
        logic reachable;
        logic overflow;
    } t_verdict;

    typedef enum int {
        SHAPE_STACKABLE,
        SHAPE_NEAR_MISS,
        SHAPE_SCRAMBLED,
        SHAPE_REVERSED
    } t_word_shape;

    localparam t_pair_row DIRECTED [N_DIRECTED] = '{
        // single-pair words right after reset
        '{8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
        // two letters swapped
        '{8'h41, 8'h42, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h42, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        // full reversal
        '{8'h01, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h02, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h03, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0},
        // order no stack can produce
        '{8'h01, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h02, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h03, 8'h02, 1'b1, 1'b0, 1'b0, 1'b0},
        // identity with extreme letters
        '{8'h5A, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hA5, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
        // repeated letters, cascade of pops on the last pair
        '{8'h07, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h07, 8'h07, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 8'h07, 1'b1, 1'b0, 1'b0, 1'b0},
        // alternating bit patterns
        '{8'h55, 8'hAA, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hAA, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    spc_in_if  in_ch ();
    spc_out_if out_ch ();

    stack_permutation_checker_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: one word in progress
    t_letter     model_stack [MAX_LETTERS];
    t_letter     model_queue [MAX_LETTERS];
    int unsigned model_depth;
    int unsigned model_head;
    int unsigned model_tail;
    bit          model_ovf;

    t_verdict    pending_verdicts [$];
    t_letter     word_src [$];
    t_letter     word_tgt [$];

    int          fail_count;
    int          cycle_count;
    int          pairs_sent;
    int          words_sent;
    int          yes_words;
    int          ovf_words;
    int          verdicts_seen;
    bit          hold_req;
    bit          hold_active;
    int          holds_done;

    // Push, enqueue, then pop while the stack top matches the queue head.
    // Returns 1 when the pair closes a word and a verdict is due.
    function automatic bit advance_word(input t_letter src, input t_letter tgt,
                                        input logic fin, output t_verdict v);
        if (model_tail >= MAX_LETTERS) begin
            model_ovf = 1'b1;
        end else begin
            model_stack[model_depth] = src;
            model_depth++;
            model_queue[model_tail] = tgt;
            model_tail++;
            while (model_depth > 0 && model_head < model_tail &&
                   model_stack[model_depth-1] == model_queue[model_head]) begin
                model_depth--;
                model_head++;
            end
        end
        v.reachable = (model_depth == 0) && !model_ovf;
        v.overflow  = model_ovf;
        if (fin) begin
            model_depth = 0;
            model_head  = 0;
            model_tail  = 0;
            model_ovf   = 1'b0;
        end
        return fin;
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(16, 40);
    endfunction

    // Offer one pair and wait for its beat; predict on acceptance
    task automatic offer_pair(input t_letter src, input t_letter tgt, input logic fin,
                              input logic typed, input logic er, input logic eo,
                              input int gap);
        t_verdict v;
        in_ch.valid         <= 1'b1;
        in_ch.source_letter <= src;
        in_ch.target_letter <= tgt;
        in_ch.final_pair    <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pairs_sent++;
        if (advance_word(src, tgt, fin, v)) begin
            if (typed) begin
                v.reachable = er;
                v.overflow  = eo;
            end
            pending_verdicts.push_back(v);
            words_sent++;
            if (v.reachable) yes_words++;
            if (v.overflow) ovf_words++;
        end
        if (gap > 0) begin
            in_ch.valid         <= 1'b0;
            in_ch.source_letter <= t_letter'($urandom);
            in_ch.target_letter <= t_letter'($urandom);
            in_ch.final_pair    <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_letter pick_letter(input bit narrow);
        return narrow ? t_letter'($urandom_range(0, 3)) : t_letter'($urandom);
    endfunction

    // Fill word_src/word_tgt with a word of the given length and shape
    task automatic compose_word(input int len, input t_word_shape shape);
        t_letter pile [$];
        bit      narrow;
        int      pops;
        int      a;
        int      b;
        t_letter tmp;
        narrow = ($urandom_range(0, 3) == 0);
        word_src.delete();
        word_tgt.delete();
        for (int i = 0; i < len; i++) word_src.push_back(pick_letter(narrow));
        case (shape)
            SHAPE_SCRAMBLED: begin
                for (int i = 0; i < len; i++) word_tgt.push_back(pick_letter(narrow));
            end
            SHAPE_REVERSED: begin
                for (int i = 0; i < len; i++) word_tgt.push_back(word_src[len-1-i]);
            end
            default: begin
                // random push/pop schedule gives a reachable target
                for (int i = 0; i < len; i++) begin
                    pile.push_back(word_src[i]);
                    pops = $urandom_range(0, pile.size());
                    repeat (pops) word_tgt.push_back(pile.pop_back());
                end
                while (pile.size() > 0) word_tgt.push_back(pile.pop_back());
                if (shape == SHAPE_NEAR_MISS && len > 1) begin
                    a = $urandom_range(0, len-1);
                    b = $urandom_range(0, len-1);
                    tmp = word_tgt[a];
                    word_tgt[a] = word_tgt[b];
                    word_tgt[b] = tmp;
                end
            end
        endcase
    endtask

    task automatic send_word(input bit burst);
        int len;
        len = word_src.size();
        for (int i = 0; i < len; i++)
            offer_pair(word_src[i], word_tgt[i], i == len-1, 1'b0, 1'b0, 1'b0,
                       pick_gap(burst));
    endtask

    // Stop offering, then wait until every verdict has come back
    task automatic wait_all_verdicts();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Result side: ready in random stretches, one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req     = 1'b0;
                hold_active  = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_active  = 1'b0;
                holds_done++;
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                if ($urandom_range(0, 3) != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (pick_gap(1'b0) + 1) @(posedge i_clk);
                end
            end
        end
    end

    // Compare each result beat with the oldest expected verdict
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                flag("result beat with no word outstanding");
            end else begin
                v = pending_verdicts.pop_front();
                if (out_ch.reachable !== v.reachable)
                    flag($sformatf("reachable exp %0b got %0b", v.reachable,
                                   out_ch.reachable));
                if (out_ch.overflow !== v.overflow)
                    flag($sformatf("overflow exp %0b got %0b", v.overflow,
                                   out_ch.overflow));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, pending_verdicts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int          rand_pairs;
        int          word_idx;
        int          len;
        int          r;
        bit          burst;
        t_word_shape shape;

        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.source_letter = '0;
        in_ch.target_letter = '0;
        in_ch.final_pair    = 1'b0;
        hold_req            = 1'b0;
        hold_active         = 1'b0;
        model_depth         = 0;
        model_head          = 0;
        model_tail          = 0;
        model_ovf           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer_pair(DIRECTED[i].src, DIRECTED[i].tgt, DIRECTED[i].fin,
                       DIRECTED[i].typed, DIRECTED[i].exp_reach, DIRECTED[i].exp_ovf,
                       pick_gap(1'b0));
        wait_all_verdicts();

        // random words
        rand_pairs = 0;
        word_idx   = 0;
        while (rand_pairs < RANDOM_PAIRS) begin
            word_idx++;

            // input backs up behind a long result hold
            if (word_idx == 3) begin
                in_ch.valid <= 1'b0;
                hold_req = 1'b1;
                while (!hold_active) @(posedge i_clk);
                for (int k = 0; k < 4; k++) begin
                    compose_word($urandom_range(2, 6), SHAPE_STACKABLE);
                    rand_pairs += word_src.size();
                    send_word(1'b1);
                end
            end

            // sender waits for every verdict now and then
            if (word_idx % 10 == 0) wait_all_verdicts();

            // one word past the store capacity
            if (word_idx == 6) begin
                compose_word(MAX_LETTERS + 6, SHAPE_STACKABLE);
                rand_pairs += word_src.size();
                send_word(1'b0);
            end

            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 8);
            else if (r < 95) len = $urandom_range(9, 32);
            else             len = $urandom_range(33, 120);
            r = $urandom_range(0, 99);
            if (r < 60)      shape = SHAPE_STACKABLE;
            else if (r < 75) shape = SHAPE_NEAR_MISS;
            else if (r < 90) shape = SHAPE_SCRAMBLED;
            else             shape = SHAPE_REVERSED;
            burst = ($urandom_range(0, 3) == 0);
            compose_word(len, shape);
            rand_pairs += len;
            send_word(burst);
        end

        wait_all_verdicts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pairs in %0d words: %0d reachable, %0d overflowed",
                 pairs_sent, words_sent, yes_words, ovf_words);
        $display("%0d verdicts checked, %0d long result holds, %0d mismatches",
                 verdicts_seen, holds_done, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/spc_pkg.sv
rtl/core/spc_in_if.sv
rtl/core/spc_out_if.sv
rtl/core/spc_ram.sv
rtl/core/spc_ctrl.sv
rtl/core/stack_permutation_checker_top.sv
tb/testbench.sv
